[rtl/bleasp_pkg.sv]
// ----------------------------------------------------------------------------
// BLE advertising sensor data parser package
// Shared constants, codes, types and helpers for the advertising parser.
// ----------------------------------------------------------------------------
package bleasp_pkg;

    localparam int unsigned MAX_PACKET_BYTES_DEF = 31;

    localparam int unsigned ADDR_W     = 48;
    localparam int unsigned CFG_ADDR_W = 1;
    localparam int unsigned CFG_DATA_W = 48;
    localparam int unsigned IN_DATA_W  = 56;
    localparam int unsigned OUT_DATA_W = 96;
    localparam int unsigned OUT_USER_W = 3;

    localparam logic [ADDR_W-1:0] TARGET_ADDRESS_RST = 48'hA4C1_38A0_0D98;
    localparam logic              FILTER_ENABLE_RST  = 1'b1;

    localparam logic [7:0]  SERVICE_DATA_KIND = 8'h16;
    localparam logic [15:0] BTHOME_UUID       = 16'hFCD2;

    // Configuration register indexes
    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_TARGET_ADDRESS = 1'b0,
        REG_FILTER_ENABLE  = 1'b1
    } cfg_reg_t;

    // Object codes that the parser understands
    typedef enum logic [1:0] {
        OBJ_PACKET_ID   = 2'd0,
        OBJ_BATTERY     = 2'd1,
        OBJ_TEMPERATURE = 2'd2,
        OBJ_HUMIDITY    = 2'd3
    } obj_code_t;

    typedef struct packed {
        logic [15:0] temperature;
        logic [15:0] humidity;
        logic [7:0]  battery;
        logic        t_valid;
        logic        h_valid;
        logic        b_valid;
        logic        encrypted;
    } reading_t;

    // Data length in bytes of an object; zero marks an unknown code.
    function automatic logic [1:0] object_length(input logic [7:0] code);
        logic [1:0] len;
        begin
            case (code)
                8'h00, 8'h01: len = 2'd1;
                8'h02, 8'h03: len = 2'd2;
                default:      len = 2'd0;
            endcase
            return len;
        end
    endfunction

endpackage

[rtl/ble_adv_sensor_data_parser.sv]
// ----------------------------------------------------------------------------
// BLE advertising sensor data parser
// Walks advertising structures byte by byte and reports sensor readings.
//
//   Channel   Direction  Handshake           Contents
//   s_axis    in         tvalid/tready       one payload byte and sender address
//   m_axis    out        tvalid/tready       one sensor reading
//   cfg       in         cfg_we              target address, filter enable
//
// One byte is taken per cycle; the parser state is updated in the same cycle
// and a reading is held in the output register from the next cycle on.
// The input stalls only while a reading waits and the sink holds tready low.
// Reset clears the parser state and loads the default configuration.
// ----------------------------------------------------------------------------
module ble_adv_sensor_data_parser
    import bleasp_pkg::*;
#(
    parameter int unsigned MAX_PACKET_BYTES = MAX_PACKET_BYTES_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,

    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // data_byte, sender_address
    input  logic                  s_tuser,   // first_byte
    input  logic                  s_tlast,   // last_byte

    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // temperature_raw, humidity_raw,
                                             // battery_level, encrypted_flag,
                                             // reading_source, zero fill
    output logic [OUT_USER_W-1:0] m_tuser    // temperature flag, humidity flag,
                                             // battery flag
);

    localparam int unsigned SEEN_W = $clog2(MAX_PACKET_BYTES + 1);
    localparam logic [SEEN_W-1:0] SEEN_MAX = SEEN_W'(MAX_PACKET_BYTES);

    // Configuration
    logic [ADDR_W-1:0] target_address_reg;
    logic              filter_enable_reg;

    // Parser state
    logic              packet_halted_reg, packet_halted_next;
    logic              address_ok_reg, address_ok_next;
    logic [ADDR_W-1:0] latched_sender_reg, latched_sender_next;
    logic [7:0]        struct_left_reg, struct_left_next;
    logic [7:0]        struct_offset_reg, struct_offset_next;
    logic [7:0]        uuid_low_reg, uuid_low_next;
    logic [1:0]        object_code_reg, object_code_next;
    logic [1:0]        object_left_reg, object_left_next;
    logic [7:0]        value_low_reg, value_low_next;
    logic              objects_halted_reg, objects_halted_next;
    reading_t          reading_reg, reading_next;
    logic [SEEN_W-1:0] seen_reg, seen_next;

    // Output register
    logic              out_valid_reg;
    reading_t          out_reading_reg;
    logic [ADDR_W-1:0] out_source_reg;

    logic              in_accept;
    logic              emit;
    logic [7:0]        data_byte;
    logic [ADDR_W-1:0] sender_address;
    logic [7:0]        left_after;
    logic [1:0]        obj_len;

    assign data_byte      = s_tdata[7:0];
    assign sender_address = s_tdata[8 +: ADDR_W];
    assign s_tready       = !out_valid_reg || m_tready;
    assign in_accept      = s_tvalid && s_tready;
    assign obj_len        = object_length(data_byte);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_address_reg <= TARGET_ADDRESS_RST;
            filter_enable_reg  <= FILTER_ENABLE_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_addr))
                REG_TARGET_ADDRESS: target_address_reg <= cfg_wdata[ADDR_W-1:0];
                REG_FILTER_ENABLE:  filter_enable_reg  <= cfg_wdata[0];
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        packet_halted_next  = packet_halted_reg;
        address_ok_next     = address_ok_reg;
        latched_sender_next = latched_sender_reg;
        struct_left_next    = struct_left_reg;
        struct_offset_next  = struct_offset_reg;
        uuid_low_next       = uuid_low_reg;
        object_code_next    = object_code_reg;
        object_left_next    = object_left_reg;
        value_low_next      = value_low_reg;
        objects_halted_next = objects_halted_reg;
        reading_next        = reading_reg;
        seen_next           = seen_reg;
        left_after          = 8'd0;
        emit                = 1'b0;

        if (in_accept)
        begin
            if (s_tuser)
            begin
                latched_sender_next = sender_address;
                address_ok_next     = !filter_enable_reg
                                      || (sender_address == target_address_reg);
                packet_halted_next  = 1'b0;
                struct_left_next    = 8'd0;
                struct_offset_next  = 8'd0;
                seen_next           = '0;
            end

            if (address_ok_next && !packet_halted_next)
            begin
                if (seen_next >= SEEN_MAX)
                begin
                    packet_halted_next = 1'b1;
                end
                else
                begin
                    seen_next = seen_next + SEEN_W'(1);
                    if (struct_left_next == 8'd0)
                    begin
                        // Length byte: zero ends the packet.
                        if (data_byte == 8'd0)
                        begin
                            packet_halted_next = 1'b1;
                        end
                        else
                        begin
                            struct_left_next    = data_byte;
                            struct_offset_next  = 8'd0;
                            object_left_next    = 2'd0;
                            objects_halted_next = 1'b0;
                            reading_next        = '0;
                        end
                    end
                    else
                    begin
                        left_after = struct_left_next - 8'd1;
                        case (struct_offset_next)
                            8'd0:
                            begin
                                objects_halted_next = (data_byte != SERVICE_DATA_KIND);
                            end
                            8'd1:
                            begin
                                uuid_low_next = data_byte;
                            end
                            8'd2:
                            begin
                                if ({data_byte, uuid_low_next} != BTHOME_UUID)
                                begin
                                    objects_halted_next = 1'b1;
                                end
                            end
                            8'd3:
                            begin
                                if (!objects_halted_next)
                                begin
                                    reading_next.encrypted = data_byte[0];
                                end
                            end
                            default:
                            begin
                                if (!objects_halted_next)
                                begin
                                    if (object_left_next == 2'd0)
                                    begin
                                        // Object code byte; stop on an unknown code
                                        // or on one whose data overruns the structure.
                                        if (obj_len == 2'd0 || {6'd0, obj_len} > left_after)
                                        begin
                                            objects_halted_next = 1'b1;
                                        end
                                        else
                                        begin
                                            object_code_next = data_byte[1:0];
                                            object_left_next = obj_len;
                                        end
                                    end
                                    else if (object_left_next == 2'd2)
                                    begin
                                        value_low_next   = data_byte;
                                        object_left_next = 2'd1;
                                    end
                                    else
                                    begin
                                        object_left_next = 2'd0;
                                        unique case (obj_code_t'(object_code_next))
                                            OBJ_BATTERY:
                                            begin
                                                reading_next.battery = data_byte;
                                                reading_next.b_valid = 1'b1;
                                            end
                                            OBJ_TEMPERATURE:
                                            begin
                                                reading_next.temperature =
                                                    {data_byte, value_low_next};
                                                reading_next.t_valid = 1'b1;
                                            end
                                            OBJ_HUMIDITY:
                                            begin
                                                reading_next.humidity =
                                                    {data_byte, value_low_next};
                                                reading_next.h_valid = 1'b1;
                                            end
                                            default: ;
                                        endcase
                                    end
                                end
                            end
                        endcase
                        struct_left_next   = left_after;
                        struct_offset_next = struct_offset_next + 8'd1;
                        emit = (left_after == 8'd0)
                               && (reading_next.t_valid || reading_next.h_valid
                                   || reading_next.b_valid);
                    end
                end
            end

            if (s_tlast)
            begin
                packet_halted_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            packet_halted_reg  <= 1'b0;
            address_ok_reg     <= 1'b0;
            latched_sender_reg <= '0;
            struct_left_reg    <= 8'd0;
            struct_offset_reg  <= 8'd0;
            uuid_low_reg       <= 8'd0;
            object_code_reg    <= 2'd0;
            object_left_reg    <= 2'd0;
            value_low_reg      <= 8'd0;
            objects_halted_reg <= 1'b0;
            reading_reg        <= '0;
            seen_reg           <= '0;
        end
        else
        begin
            packet_halted_reg  <= packet_halted_next;
            address_ok_reg     <= address_ok_next;
            latched_sender_reg <= latched_sender_next;
            struct_left_reg    <= struct_left_next;
            struct_offset_reg  <= struct_offset_next;
            uuid_low_reg       <= uuid_low_next;
            object_code_reg    <= object_code_next;
            object_left_reg    <= object_left_next;
            value_low_reg      <= value_low_next;
            objects_halted_reg <= objects_halted_next;
            reading_reg        <= reading_next;
            seen_reg           <= seen_next;
        end
    end

    // A finished reading sits here until the sink takes the transaction.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_reading_reg <= reading_next;
            out_source_reg  <= latched_sender_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_source_reg, out_reading_reg.encrypted,
                       out_reading_reg.battery, out_reading_reg.humidity,
                       out_reading_reg.temperature};
    assign m_tuser  = {out_reading_reg.b_valid, out_reading_reg.h_valid,
                       out_reading_reg.t_valid};

endmodule
